// ===== rtl/core/fwrv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrv_pkg
// Shared commands, status codes, defaults and the cell control bundle for the
// token queue with remove-by-value.
// ----------------------------------------------------------------------------
package fwrv_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int TOKEN_W_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int IO_TOK_W = 32;
  localparam int FILL_W   = 5;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RM  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CNT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic shift;        // take the right neighbour's entry
    logic keep_passed;  // cells already scanned hold their entry during a shift
    logic enq;          // tail cell loads the token
    logic scan;         // current scan cell marks itself passed
    logic clr_pass;     // restart the scan at the head
  } cell_ctrl_t;

endpackage

// ===== rtl/core/fwrv_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrv_cell
// One queue slot: holds an entry, compares it against the search token and
// takes over its right neighbour's entry when the queue closes up.
// ----------------------------------------------------------------------------
module fwrv_cell
  import fwrv_pkg::*;
#(
  parameter int TOKEN_W = TOKEN_W_DEF,
  parameter int CNT_W   = 5,
  parameter int IDX     = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic [TOKEN_W-1:0] tok,
  input  logic [CNT_W-1:0]   count,
  input  logic [TOKEN_W-1:0] right_data,
  input  logic               left_pass,
  output logic [TOKEN_W-1:0] data,
  output logic               pass,
  output logic               hit,
  output logic               scan_end
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [TOKEN_W-1:0] data_r, data_nxt;
  logic               pass_r, pass_nxt;
  logic               cur;
  logic               occupied;

  // the scan front sits at the first cell not yet passed
  assign cur      = ~pass_r & left_pass;
  assign occupied = (IDX_C < count);
  assign hit      = cur & occupied & (data_r == tok);
  assign scan_end = cur & ~occupied;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift && !(ctrl.keep_passed && pass_r)) begin
      data_nxt = right_data;
    end else if (ctrl.enq && (count == IDX_C)) begin
      data_nxt = tok;
    end
  end

  always_comb begin
    pass_nxt = pass_r;
    if (ctrl.clr_pass) begin
      pass_nxt = 1'b0;
    end else if (ctrl.scan && cur) begin
      pass_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
    end else begin
      pass_r <= pass_nxt;
    end
  end

  assign data = data_r;
  assign pass = pass_r;

endmodule

// ===== rtl/core/fifo_with_remove_by_value.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_remove_by_value
// Ordered queue of nonzero tokens with enqueue, dequeue, remove-by-value and
// fill-level read, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Enqueue, dequeue and count: the command is taken when start is high and
// busy is low, and its result appears with out_valid on the next cycle.
// Remove walks a scan front from the head along the cell chain, one cell per
// cycle, and returns at the first match, or with a miss once the front passes
// the last occupied cell; a zero token is rejected without a scan, with its
// result on the next cycle. busy is high while a scan runs. Every result is
// presented for a single cycle and the receiver cannot stall it; fill_level
// reports the occupancy after the command.
// ----------------------------------------------------------------------------
module fifo_with_remove_by_value
  import fwrv_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int TOKEN_W = TOKEN_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [IO_TOK_W-1:0] in_token,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [IO_TOK_W-1:0] out_token_out,
  output logic [FILL_W-1:0]   out_fill_level
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TOKEN_W-1:0]  tok_r, tok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [TOKEN_W-1:0]  out_tok_r, out_tok_nxt;

  logic                accept;
  logic [TOKEN_W+IO_TOK_W-1:0] tok_wide;
  logic [TOKEN_W-1:0]  in_tok;
  logic [TOKEN_W-1:0]  cell_tok;
  cell_ctrl_t          ctrl;

  logic [TOKEN_W-1:0]  cell_data [DEPTH];
  logic [DEPTH-1:0]    pass_vec;
  logic [DEPTH-1:0]    hit_vec;
  logic [DEPTH-1:0]    end_vec;

  logic [IO_TOK_W+TOKEN_W-1:0] out_wide;
  logic [FILL_W+CNT_W-1:0]     fill_wide;

  // token masked to TOKEN_W after the 32-bit port
  assign tok_wide = {{TOKEN_W{1'b0}}, in_token};
  assign in_tok   = tok_wide[TOKEN_W-1:0];
  assign accept   = start & ~busy;
  assign busy     = (state_r == S_SCAN);
  assign cell_tok = (state_r == S_SCAN) ? tok_r : in_tok;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [TOKEN_W-1:0] right_d;
      logic               left_p;
      if (g == DEPTH - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid
        assign right_d = cell_data[g+1];
      end
      if (g == 0) begin : g_head
        assign left_p = 1'b1;
      end else begin : g_body
        assign left_p = pass_vec[g-1];
      end

      fwrv_cell #(
        .TOKEN_W (TOKEN_W),
        .CNT_W   (CNT_W),
        .IDX     (g)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .tok        (cell_tok),
        .count      (count_r),
        .right_data (right_d),
        .left_pass  (left_p),
        .data       (cell_data[g]),
        .pass       (pass_vec[g]),
        .hit        (hit_vec[g]),
        .scan_end   (end_vec[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    tok_nxt        = tok_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_tok_nxt    = '0;
    ctrl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_ENQ: begin
              out_valid_nxt = 1'b1;
              if (in_tok == '0) begin
                out_status_nxt = ST_ZERO;
              end else if (count_r == DEPTH_C) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.enq  = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_DEQ: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                ctrl.shift  = 1'b1;
                out_tok_nxt = cell_data[0];
                count_nxt   = count_r - 1'b1;
              end
            end
            CMD_RM: begin
              if (in_tok == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_ZERO;
              end else begin
                tok_nxt       = in_tok;
                ctrl.clr_pass = 1'b1;
                state_nxt     = S_SCAN;
              end
            end
            CMD_CNT: begin
              out_valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (|hit_vec) begin
          // close the gap behind the first match; passed cells stay put
          ctrl.shift       = 1'b1;
          ctrl.keep_passed = 1'b1;
          count_nxt        = count_r - 1'b1;
          out_valid_nxt    = 1'b1;
          out_tok_nxt      = tok_r;
          state_nxt        = S_IDLE;
        end else if ((|end_vec) || pass_vec[DEPTH-1]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end else begin
          ctrl.scan = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (out_valid_nxt) begin
      out_status_r <= out_status_nxt;
      out_tok_r    <= out_tok_nxt;
    end
  end

  assign out_wide  = {{IO_TOK_W{1'b0}}, out_tok_r};
  assign fill_wide = {{FILL_W{1'b0}}, count_r};

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_token_out  = out_wide[IO_TOK_W-1:0];
  assign out_fill_level = fill_wide[FILL_W-1:0];

endmodule

// ===== rtl/core/fwrv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrv_checker
// Port-level checks on the token queue: result timing, status range and
// fill-level consistency.
// ----------------------------------------------------------------------------
module fwrv_checker
  import fwrv_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [CMD_W-1:0]    in_cmd,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [IO_TOK_W-1:0] out_token_out,
  input logic [FILL_W-1:0]   out_fill_level
);

  // enqueue, dequeue and count commands return on the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd != CMD_RM) |=> out_valid)
    else $error("single-cycle command gave no result");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_fill_level) <= DEPTH))
    else $error("fill level beyond capacity");

  a_fail_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_token_out == '0))
    else $error("failed transaction carries a token");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_FULL))
    else $error("undefined status code");

  // occupancy only moves through a completed transaction
  a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !$past(out_valid) && $past(rst_n)) |-> $stable(out_fill_level))
    else $error("fill level moved without a result");

endmodule

bind fifo_with_remove_by_value fwrv_checker #(.DEPTH(DEPTH)) u_fwrv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_token_out  (out_token_out),
  .out_fill_level (out_fill_level)
);
